// ----- rtl/core/cc20_pkg.sv -----
// Shared types, constants and helper functions for the ChaCha20 stream cipher unit.
package cc20_pkg;

  // Round structure: each double round is a column round followed by a diagonal round.
  localparam int DOUBLE_ROUNDS = 10;
  localparam int ROUNDS        = 2 * DOUBLE_ROUNDS;
  localparam int RND_W         = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

  // Item and block geometry.
  localparam int BYTES_PER_ITEM = 8;
  localparam int ITEM_BYTES     = (BYTES_PER_ITEM < 8) ? BYTES_PER_ITEM : 8;
  localparam logic [3:0] ITEM_CNT = 4'(ITEM_BYTES);
  localparam int BLOCK_BYTES    = 64;
  localparam int AVAIL_W        = $clog2(BLOCK_BYTES + 1);

  // The four constant words at the head of the state.
  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  typedef logic [31:0] word_t;

  // Input and result payloads.
  typedef struct packed {
    logic [63:0] data_in;
    logic [3:0]  byte_count;
    logic        message_start;
  } in_item_t;

  typedef struct packed {
    logic [63:0] data_out;
    logic [3:0]  out_byte_count;
  } out_item_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_KEY_WORD_0    = 3'd0,
    CFG_KEY_WORD_1    = 3'd1,
    CFG_KEY_WORD_2    = 3'd2,
    CFG_KEY_WORD_3    = 3'd3,
    CFG_NONCE_LOW     = 3'd4,
    CFG_NONCE_HIGH    = 3'd5,
    CFG_START_COUNTER = 3'd6
  } cfg_index_t;

  // Block generator sequencing.
  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_RUN,
    CORE_DONE
  } core_state_t;

  // Control broadcast to every quarter-round cell.
  typedef struct packed {
    logic load;
    logic step;
    logic phase;
  } cell_ctl_t;

  // Status of the block generator toward the stream logic.
  typedef struct packed {
    logic busy;
    logic done;
  } core_sts_t;

  // Rotate a word left by the given amount.
  function automatic word_t rotl(word_t x, logic [4:0] n);
    rotl = (x << n) | (x >> (6'd32 - {1'b0, n}));
  endfunction

  // Mask with the given number of low-order bytes set.
  function automatic logic [63:0] byte_mask(logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < n) begin
        m[8*i +: 8] = 8'hff;
      end
    end
    byte_mask = m;
  endfunction

endpackage

// ----- rtl/core/cc20_qr_cell.sv -----
// Quarter-round cell: holds one state column and does half a quarter round per step.
module cc20_qr_cell (
  input  logic                   clk,
  input  cc20_pkg::cell_ctl_t    ctl,
  input  logic [3:0][31:0]       col_init,
  input  cc20_pkg::word_t        in_b,
  input  cc20_pkg::word_t        in_c,
  input  cc20_pkg::word_t        in_d,
  output cc20_pkg::word_t        f_b,
  output cc20_pkg::word_t        f_c,
  output cc20_pkg::word_t        f_d,
  output logic [3:0][31:0]       sum
);

  cc20_pkg::word_t a_r, b_r, c_r, d_r;
  cc20_pkg::word_t a_nxt, b_nxt, c_nxt, d_nxt;
  cc20_pkg::word_t a1, b1, c1, d1;
  logic [4:0]      rot_ad, rot_cb;

  // Half quarter round; the second half uses the smaller rotations.
  always_comb begin
    rot_ad = ctl.phase ? 5'd8 : 5'd16;
    rot_cb = ctl.phase ? 5'd7 : 5'd12;
    a1 = a_r + b_r;
    d1 = cc20_pkg::rotl(d_r ^ a1, rot_ad);
    c1 = c_r + d1;
    b1 = cc20_pkg::rotl(b_r ^ c1, rot_cb);
  end

  assign f_b = b1;
  assign f_c = c1;
  assign f_d = d1;

  // At the end of a round the b, c and d words arrive from neighboring cells.
  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    c_nxt = c_r;
    d_nxt = d_r;
    if (ctl.load) begin
      a_nxt = col_init[0];
      b_nxt = col_init[1];
      c_nxt = col_init[2];
      d_nxt = col_init[3];
    end else if (ctl.step) begin
      a_nxt = a1;
      b_nxt = ctl.phase ? in_b : b1;
      c_nxt = ctl.phase ? in_c : c1;
      d_nxt = ctl.phase ? in_d : d1;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
    d_r <= d_nxt;
  end

  // Feed-forward of the input column gives this column's keystream words.
  assign sum[0] = a_r + col_init[0];
  assign sum[1] = b_r + col_init[1];
  assign sum[2] = c_r + col_init[2];
  assign sum[3] = d_r + col_init[3];

endmodule

// ----- rtl/core/cc20_round_core.sv -----
// Block generator: a row of four quarter-round cells and the round sequencer.
module cc20_round_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [15:0][31:0]    init,
  output cc20_pkg::core_sts_t  sts,
  output logic [15:0][31:0]    ks
);

  cc20_pkg::core_state_t    state_r, state_nxt;
  logic [cc20_pkg::RND_W-1:0] rnd_r, rnd_nxt;
  logic                     phase_r, phase_nxt;
  cc20_pkg::cell_ctl_t      ctl;
  logic                     last_step;
  logic                     to_diag;

  cc20_pkg::word_t  f_b [4];
  cc20_pkg::word_t  f_c [4];
  cc20_pkg::word_t  f_d [4];
  cc20_pkg::word_t  in_b [4];
  cc20_pkg::word_t  in_c [4];
  cc20_pkg::word_t  in_d [4];
  logic [3:0][31:0] cinit [4];
  logic [3:0][31:0] csum [4];

  assign last_step = phase_r && (rnd_r == cc20_pkg::RND_W'(cc20_pkg::ROUNDS - 1));
  // Even rounds work on columns and hand over into diagonal order.
  assign to_diag   = ~rnd_r[0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cc20_pkg::CORE_IDLE: begin
        if (start) begin
          state_nxt = cc20_pkg::CORE_RUN;
        end
      end
      cc20_pkg::CORE_RUN: begin
        if (last_step) begin
          state_nxt = cc20_pkg::CORE_DONE;
        end
      end
      cc20_pkg::CORE_DONE: begin
        state_nxt = cc20_pkg::CORE_IDLE;
      end
      default: begin
        state_nxt = cc20_pkg::CORE_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    ctl.load  = (state_r == cc20_pkg::CORE_IDLE) && start;
    ctl.step  = (state_r == cc20_pkg::CORE_RUN);
    ctl.phase = phase_r;
    sts.busy  = (state_r != cc20_pkg::CORE_IDLE);
    sts.done  = (state_r == cc20_pkg::CORE_DONE);
  end

  // Round and half-round counters.
  always_comb begin
    rnd_nxt   = rnd_r;
    phase_nxt = phase_r;
    if (ctl.load) begin
      rnd_nxt   = '0;
      phase_nxt = 1'b0;
    end else if (ctl.step) begin
      phase_nxt = ~phase_r;
      if (phase_r) begin
        rnd_nxt = rnd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cc20_pkg::CORE_IDLE;
      rnd_r   <= '0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      phase_r <= phase_nxt;
    end
  end

  // Row of cells; cell j holds column j, or diagonal j during a diagonal round.
  for (genvar j = 0; j < 4; j++) begin : g_cell
    assign cinit[j][0] = init[j];
    assign cinit[j][1] = init[4 + j];
    assign cinit[j][2] = init[8 + j];
    assign cinit[j][3] = init[12 + j];

    assign in_b[j] = to_diag ? f_b[(j + 1) % 4] : f_b[(j + 3) % 4];
    assign in_c[j] = f_c[(j + 2) % 4];
    assign in_d[j] = to_diag ? f_d[(j + 3) % 4] : f_d[(j + 1) % 4];

    cc20_qr_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .col_init (cinit[j]),
      .in_b     (in_b[j]),
      .in_c     (in_c[j]),
      .in_d     (in_d[j]),
      .f_b      (f_b[j]),
      .f_c      (f_c[j]),
      .f_d      (f_d[j]),
      .sum      (csum[j])
    );

    for (genvar r = 0; r < 4; r++) begin : g_row
      assign ks[4*r + j] = csum[j][r];
    end
  end

endmodule

// ----- rtl/core/chacha20_stream_cipher_unit.sv -----
// ChaCha20 stream cipher unit: XORs up to eight data bytes per item with the keystream.
// Input items arrive on in_valid/in_stall/in_data and each gives one result on
// out_valid/out_stall/out_data. Key, nonce and starting counter are written through
// cfg_we/cfg_index/cfg_wdata, and the user must write them only while the unit is
// idle; the unit itself does not enforce this. An item with message_start set restarts the
// keystream at the configured counter, byte zero. An item whose bytes are all left in
// the current keystream block passes from the item register to the output register
// without waiting, and such items flow at one per cycle while out_stall is low. An item
// that needs a new block waits for the block generator: a load, 40 half-round steps
// through four quarter-round cells and a feed-forward. A block holds eight full items.
// Reset (rst_n low at a clock edge) clears the control and configuration registers,
// empties the pipeline and restarts the keystream at counter zero. A stalled result
// stays in the output register; one more item is held behind it, then in_stall rises.
module chacha20_stream_cipher_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cc20_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cc20_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [63:0]          cfg_wdata
);

  // Configuration registers.
  logic [63:0] key_r [4];
  logic [63:0] key_nxt [4];
  logic [63:0] nonce_lo_r, nonce_lo_nxt;
  logic [31:0] nonce_hi_r, nonce_hi_nxt;
  logic [31:0] start_ctr_r, start_ctr_nxt;

  // Keystream state.
  logic [31:0]                  ctr_r, ctr_nxt;
  logic [511:0]                 blk_r, blk_nxt;
  logic [cc20_pkg::AVAIL_W-1:0] blk_avail_r, blk_avail_nxt;

  // Item in progress.
  logic        itm_vld_r, itm_vld_nxt;
  logic [63:0] itm_data_r, itm_data_nxt;
  logic [3:0]  itm_cnt_r, itm_cnt_nxt;
  logic [3:0]  itm_done_r, itm_done_nxt;
  logic [63:0] itm_ks_r, itm_ks_nxt;

  // Output register.
  logic                out_vld_r, out_vld_nxt;
  cc20_pkg::out_item_t out_pl_r, out_pl_nxt;

  logic [15:0][31:0]   init;
  logic [15:0][31:0]   ks;
  cc20_pkg::core_sts_t core_sts;
  logic                core_start;
  logic [3:0]          rem;
  logic [3:0]          take;
  logic [3:0]          done_upd;
  logic [63:0]         piece;
  logic [63:0]         acc_upd;
  logic [3:0]          cnt_in;
  logic                fin;
  logic                out_ld;
  logic                in_acc;

  // Register writes; an unknown index is ignored.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      key_nxt[k] = key_r[k];
    end
    nonce_lo_nxt  = nonce_lo_r;
    nonce_hi_nxt  = nonce_hi_r;
    start_ctr_nxt = start_ctr_r;
    if (cfg_we) begin
      case (cfg_index)
        cc20_pkg::CFG_KEY_WORD_0:    key_nxt[0]    = cfg_wdata;
        cc20_pkg::CFG_KEY_WORD_1:    key_nxt[1]    = cfg_wdata;
        cc20_pkg::CFG_KEY_WORD_2:    key_nxt[2]    = cfg_wdata;
        cc20_pkg::CFG_KEY_WORD_3:    key_nxt[3]    = cfg_wdata;
        cc20_pkg::CFG_NONCE_LOW:     nonce_lo_nxt  = cfg_wdata;
        cc20_pkg::CFG_NONCE_HIGH:    nonce_hi_nxt  = cfg_wdata[31:0];
        cc20_pkg::CFG_START_COUNTER: start_ctr_nxt = cfg_wdata[31:0];
        default: begin
        end
      endcase
    end
  end

  // Input state of the block: constants, key, counter, nonce.
  always_comb begin
    init[0] = cc20_pkg::SIGMA0;
    init[1] = cc20_pkg::SIGMA1;
    init[2] = cc20_pkg::SIGMA2;
    init[3] = cc20_pkg::SIGMA3;
    for (int k = 0; k < 4; k++) begin
      init[4 + 2*k] = key_r[k][31:0];
      init[5 + 2*k] = key_r[k][63:32];
    end
    init[12] = ctr_r;
    init[13] = nonce_lo_r[31:0];
    init[14] = nonce_lo_r[63:32];
    init[15] = nonce_hi_r;
  end

  cc20_round_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .start (core_start),
    .init  (init),
    .sts   (core_sts),
    .ks    (ks)
  );

  // Bytes taken from the current block this cycle and the transfer handshakes.
  always_comb begin
    rem  = itm_cnt_r - itm_done_r;
    take = '0;
    if (itm_vld_r) begin
      take = (blk_avail_r < cc20_pkg::AVAIL_W'(rem)) ? blk_avail_r[3:0] : rem;
    end
    done_upd   = itm_done_r + take;
    piece      = (blk_r[63:0] & cc20_pkg::byte_mask(take)) << {itm_done_r[2:0], 3'b000};
    acc_upd    = itm_ks_r | piece;
    fin        = itm_vld_r && (done_upd == itm_cnt_r);
    out_ld     = fin && (!out_vld_r || !out_stall);
    in_stall   = itm_vld_r && !out_ld;
    in_acc     = in_valid && !in_stall;
    core_start = itm_vld_r && (rem != '0) && (blk_avail_r == '0) && !core_sts.busy;
  end

  // Byte count as used: zero counts as one, large counts saturate at the item size.
  always_comb begin
    cnt_in = in_data.byte_count;
    if (cnt_in == '0) begin
      cnt_in = 4'd1;
    end else if (cnt_in > cc20_pkg::ITEM_CNT) begin
      cnt_in = cc20_pkg::ITEM_CNT;
    end
  end

  // Item register: loads on a transfer, otherwise gathers keystream bytes.
  always_comb begin
    itm_vld_nxt  = in_acc || (itm_vld_r && !out_ld);
    itm_data_nxt = itm_data_r;
    itm_cnt_nxt  = itm_cnt_r;
    itm_done_nxt = done_upd;
    itm_ks_nxt   = acc_upd;
    if (in_acc) begin
      itm_data_nxt = in_data.data_in;
      itm_cnt_nxt  = cnt_in;
      itm_done_nxt = '0;
      itm_ks_nxt   = '0;
    end
  end

  // Keystream block: shifts out used bytes, reloads when made, empties on message_start.
  always_comb begin
    blk_nxt       = blk_r >> {take, 3'b000};
    blk_avail_nxt = blk_avail_r - cc20_pkg::AVAIL_W'(take);
    ctr_nxt       = ctr_r;
    if (core_sts.done) begin
      blk_nxt       = ks;
      blk_avail_nxt = cc20_pkg::AVAIL_W'(cc20_pkg::BLOCK_BYTES);
      ctr_nxt       = ctr_r + 32'd1;
    end
    if (in_acc && in_data.message_start) begin
      blk_avail_nxt = '0;
      ctr_nxt       = start_ctr_r;
    end
  end

  // Output register.
  always_comb begin
    out_vld_nxt = out_ld || (out_vld_r && out_stall);
    out_pl_nxt  = out_pl_r;
    if (out_ld) begin
      out_pl_nxt.data_out       = (itm_data_r & cc20_pkg::byte_mask(itm_cnt_r)) ^ acc_upd;
      out_pl_nxt.out_byte_count = itm_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) begin
        key_r[k] <= '0;
      end
      nonce_lo_r  <= '0;
      nonce_hi_r  <= '0;
      start_ctr_r <= '0;
      ctr_r       <= '0;
      blk_avail_r <= '0;
      itm_vld_r   <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      for (int k = 0; k < 4; k++) begin
        key_r[k] <= key_nxt[k];
      end
      nonce_lo_r  <= nonce_lo_nxt;
      nonce_hi_r  <= nonce_hi_nxt;
      start_ctr_r <= start_ctr_nxt;
      ctr_r       <= ctr_nxt;
      blk_avail_r <= blk_avail_nxt;
      itm_vld_r   <= itm_vld_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    blk_r      <= blk_nxt;
    itm_data_r <= itm_data_nxt;
    itm_cnt_r  <= itm_cnt_nxt;
    itm_done_r <= itm_done_nxt;
    itm_ks_r   <= itm_ks_nxt;
    out_pl_r   <= out_pl_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_pl_r;

`ifndef ASSERT_OFF
  // A freshly generated block is whole in the next cycle.
  a_block_full: assert property (@(posedge clk) disable iff (!rst_n)
    core_sts.done |=> blk_avail_r == cc20_pkg::AVAIL_W'(cc20_pkg::BLOCK_BYTES))
    else $error("keystream block not full after generation");

  // The generator only runs on behalf of a pending item.
  a_core_owner: assert property (@(posedge clk) disable iff (!rst_n)
    core_sts.busy |-> itm_vld_r)
    else $error("block generator busy without a pending item");

  // An item never gathers more keystream bytes than it carries.
  a_item_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    itm_vld_r |-> itm_done_r <= itm_cnt_r)
    else $error("item byte progress beyond its count");

  // Every result carries a byte count in the valid range.
  a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.out_byte_count != '0) &&
                  (out_data.out_byte_count <= cc20_pkg::ITEM_CNT))
    else $error("result byte count out of range");
`endif

endmodule
